### rtl/assert_macros.svh
// assertion macros shared by the checker file
// each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define CHK_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("check failed: %m");

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: %m");

`endif

### rtl/x87sfp_pkg.sv
package x87sfp_pkg;

	// extended format
	localparam logic [14:0] EXT_BIAS    = 15'd16383;
	localparam logic [14:0] SGL_BIAS    = 15'd127;
	// normal single: e15 = ex - 127 + 16383
	localparam logic [14:0] NORM_OFFSET = EXT_BIAS - SGL_BIAS;
	// subnormal single: e15 = 16383 - 149 + p
	localparam logic [14:0] SUB_OFFSET  = EXT_BIAS - 15'd149;

	localparam logic [7:0] SGL_EXP_SPECIAL = 8'hFF;

	// status word TOP field
	localparam int TOP_LSB = 11;
	localparam int TOP_MSB = 13;

	// tag codes
	localparam logic [1:0] TAG_VALID = 2'b00;
	localparam logic [1:0] TAG_ZERO  = 2'b01;
	localparam logic [15:0] TAGS_EMPTY = 16'hFFFF;

	localparam int STACK_DEPTH = 8;
	localparam int REG_WIDTH   = 80;

endpackage

### rtl/x87sfp_ram.sv
module x87sfp_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/x87_single_float_push.sv
// channel | direction | handshake           | payload
// --------+-----------+---------------------+--------------------------------------
// in      | in        | in_valid/in_stall   | value_bits
// out     | out       | out_valid/out_stall | accepted, significand, sign_exponent,
//         |           |                     | stack_top, status_out, tags_out
//
// one push steps through the sequencer states in order: the accept edge writes the stack
// ram and enters ST_READ, which reads the same entry back through the ram's registered
// read port; ST_OUT raises out_valid and holds it until the result is taken
// a new request is taken only after the sequencer is back in ST_IDLE
// in_stall is high from acceptance until the result has been taken
// reset clears TOP, the status word and marks all tags empty; ram needs no clearing

module x87_single_float_push (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [63:0] significand,
	output logic [15:0] sign_exponent,
	output logic [2:0]  stack_top,
	output logic [15:0] status_out,
	output logic [15:0] tags_out
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
	localparam logic [1:0] ST_READ = 2'd1;  // read back the written entry
	localparam logic [1:0] ST_OUT  = 2'd2;  // result presented

	logic [1:0]  state_q;
	logic [2:0]  top_q;
	logic [15:0] tags_q;
	logic        acc_q;

	logic        in_fire;
	logic        out_fire;

	// field split
	logic        sgn;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic        is_special;
	logic        is_zero;

	// conversion
	logic [4:0]  lead_pos;
	logic [5:0]  sub_shift;
	logic [63:0] sig;
	logic [14:0] e15;
	logic [15:0] se;
	logic [2:0]  new_top;
	logic        do_push;

	// ram ports
	logic [x87sfp_pkg::REG_WIDTH-1:0] ram_wdata;
	logic [x87sfp_pkg::REG_WIDTH-1:0] ram_rdata;
	logic                             ram_rd_en;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	assign sgn = value_bits[31];
	assign ex  = value_bits[30:23];
	assign fr  = value_bits[22:0];

	assign is_special = (ex == x87sfp_pkg::SGL_EXP_SPECIAL);
	assign is_zero    = (ex == 8'd0) && (fr == 23'd0);

	// index of the highest set fraction bit, for subnormals
	always_comb begin
		lead_pos = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (fr[i]) begin
				lead_pos = 5'(i);
			end
		end
	end

	assign sub_shift = 6'd63 - {1'b0, lead_pos};

	always_comb begin
		if (ex != 8'd0) begin
			// normal: explicit integer bit over the fraction
			sig = {1'b1, fr, 40'd0};
			e15 = {7'd0, ex} + x87sfp_pkg::NORM_OFFSET;
		end else begin
			// subnormal: leading one moved up to bit 63
			sig = {41'd0, fr} << sub_shift;
			e15 = {10'd0, lead_pos} + x87sfp_pkg::SUB_OFFSET;
		end
	end

	// zeros of either sign collapse to all zero
	assign se        = is_zero ? 16'd0 : {sgn, e15};
	assign ram_wdata = is_zero ? '0 : {se, sig};

	assign new_top = top_q - 3'd1;
	assign do_push = in_fire && !is_special;

	// stack registers; written on the accept edge, read back the cycle after
	assign ram_rd_en = (state_q == ST_READ);

	x87sfp_ram #(
		.WIDTH(x87sfp_pkg::REG_WIDTH),
		.DEPTH(x87sfp_pkg::STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (new_top),
		.wr_data (ram_wdata),
		.rd_en   (ram_rd_en),
		.rd_addr (top_q),
		.rd_data (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// TOP and tag word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= 3'd0;
			tags_q <= x87sfp_pkg::TAGS_EMPTY;
			acc_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				acc_q <= !is_special;
			end
			if (do_push) begin
				top_q <= new_top;
				for (int i = 0; i < x87sfp_pkg::STACK_DEPTH; i++) begin
					if (3'(i) == new_top) begin
						tags_q[2*i +: 2] <= is_zero ? x87sfp_pkg::TAG_ZERO
						                            : x87sfp_pkg::TAG_VALID;
					end
				end
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// rejected requests report zero payload and the unchanged state
	assign accepted      = acc_q;
	assign significand   = acc_q ? ram_rdata[63:0] : 64'd0;
	assign sign_exponent = acc_q ? ram_rdata[79:64] : 16'd0;
	assign stack_top     = top_q;
	assign status_out    = {2'd0, top_q, 11'd0};
	assign tags_out      = tags_q;

endmodule

### rtl/x87sfp_checker.sv
`include "assert_macros.svh"

module x87sfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        accepted,
	input logic [63:0] significand,
	input logic [15:0] sign_exponent,
	input logic [2:0]  stack_top
);

	// a taken request is followed by a blocked input
	`CHK_NEXT(a_in_blocks, in_valid && !in_stall, in_stall)

	// a rejected request carries an empty payload
	`CHK_ALWAYS(a_reject_zero, !(out_valid && !accepted) || ({significand, sign_exponent} == '0))

	// a nonzero pushed value is normalized
	`CHK_ALWAYS(a_normalized, !(out_valid && accepted && significand != 64'd0) || significand[63])

	// one result per request: after a taken result the output goes idle
	`CHK_NEXT(a_single_result, out_valid && !out_stall, !out_valid)

	// a stalled result holds
	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(significand) && $stable(stack_top))

endmodule

bind x87_single_float_push x87sfp_checker u_x87sfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.accepted      (accepted),
	.significand   (significand),
	.sign_exponent (sign_exponent),
	.stack_top     (stack_top)
);

### tb/x87_single_float_push_tb.sv
`timescale 1ns / 1ps

module x87_single_float_push_tb;

	// watchdog: cycles in a row with no request or result taken
	localparam int IDLE_LIMIT = 1000;
	// cycles allowed after the last result for stray outputs to show up
	localparam int TAIL_CYCLES = 12;
	// receiver hold-off that backs the block up into its input
	localparam int LONG_HOLD = 80;
	localparam int HOLD_AFTER = 200;
	localparam int RANDOM_PUSHES = 550;

	typedef struct {
		logic [31:0] bits;
		bit          drain; // wait for every outstanding result before offering
	} push_request_t;

	typedef struct {
		logic        accepted;
		logic [63:0] significand;
		logic [15:0] sign_exponent;
		logic [2:0]  stack_top;
		logic [15:0] status_word;
		logic [15:0] tag_word;
	} push_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] value_bits = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [63:0] significand;
	logic [15:0] sign_exponent;
	logic [2:0]  stack_top;
	logic [15:0] status_out;
	logic [15:0] tags_out;

	x87_single_float_push dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value_bits   (value_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.significand  (significand),
		.sign_exponent(sign_exponent),
		.stack_top    (stack_top),
		.status_out   (status_out),
		.tags_out     (tags_out)
	);

	always #5 clk = ~clk;

	// shadow of the fpu state the block keeps
	logic [79:0] shadow_stack [x87sfp_pkg::STACK_DEPTH];
	logic [15:0] shadow_status;
	logic [15:0] shadow_tags;

	push_request_t queued_values [$];
	push_result_t  expected_pushes [$];

	int  mismatches = 0;
	int  results_taken = 0;
	bit  in_took = 1'b0;
	bit  out_took = 1'b0;

	// converts one single to extended and pushes it on the shadow stack
	function automatic push_result_t push_single(input logic [31:0] bits);
		push_result_t r;
		logic         sgn;
		logic [7:0]   ex;
		logic [22:0]  fr;
		logic [14:0]  e15;
		logic [2:0]   new_top;
		int           lead;
		sgn = bits[31];
		ex = bits[30:23];
		fr = bits[22:0];
		r.accepted = 1'b0;
		r.significand = '0;
		r.sign_exponent = '0;
		// infinity and nan: nothing changes, report the current state
		if (ex == x87sfp_pkg::SGL_EXP_SPECIAL) begin
			r.stack_top = shadow_status[x87sfp_pkg::TOP_MSB:x87sfp_pkg::TOP_LSB];
			r.status_word = shadow_status;
			r.tag_word = shadow_tags;
			return r;
		end
		if (ex != 8'd0) begin
			// normal: explicit integer bit, fraction right below it
			r.significand = {1'b1, fr, 40'd0};
			e15 = x87sfp_pkg::NORM_OFFSET + 15'(ex);
			r.sign_exponent = {sgn, e15};
		end else if (fr != 23'd0) begin
			// subnormal: shift the highest set fraction bit up to bit 63
			lead = 0;
			for (int i = 0; i < 23; i++)
				if (fr[i])
					lead = i;
			r.significand = 64'(fr) << (63 - lead);
			e15 = x87sfp_pkg::SUB_OFFSET + 15'(lead);
			r.sign_exponent = {sgn, e15};
		end
		// zero of either sign stays all zero, sign dropped
		new_top = shadow_status[x87sfp_pkg::TOP_MSB:x87sfp_pkg::TOP_LSB] - 3'd1;
		shadow_stack[new_top] = {r.sign_exponent, r.significand};
		shadow_status[x87sfp_pkg::TOP_MSB:x87sfp_pkg::TOP_LSB] = new_top;
		shadow_tags[2 * new_top +: 2] = (ex == 8'd0 && fr == 23'd0) ?
			x87sfp_pkg::TAG_ZERO : x87sfp_pkg::TAG_VALID;
		r.accepted = 1'b1;
		r.stack_top = new_top;
		r.status_word = shadow_status;
		r.tag_word = shadow_tags;
		return r;
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
		end
	endtask

	// wait length for one request or result, with occasional runs of no waiting
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(15, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// monitor: predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		push_result_t want;
		in_took <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_pushes.push_back(push_single(value_bits));
			if (out_valid && !out_stall) begin
				results_taken <= results_taken + 1;
				if (expected_pushes.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, expected none, actual %h",
						$time, significand);
				end else begin
					want = expected_pushes.pop_front();
					check_field("accepted", 64'(want.accepted), 64'(accepted));
					check_field("significand", want.significand, significand);
					check_field("sign_exponent", 64'(want.sign_exponent), 64'(sign_exponent));
					check_field("stack_top", 64'(want.stack_top), 64'(stack_top));
					check_field("status_out", 64'(want.status_word), 64'(status_out));
					check_field("tags_out", 64'(want.tag_word), 64'(tags_out));
				end
			end
		end
	end

	// driver: offers queued requests with random gaps, holds a stalled one steady
	int send_gap = 0;
	int send_burst = 0;

	always @(negedge clk) begin
		bit offering;
		push_request_t req;
		if (arst_n) begin
			offering = in_valid;
			if (offering && in_took)
				offering = 1'b0;
			if (!offering) begin
				if (send_gap > 0)
					send_gap--;
				else if (queued_values.size() > 0 &&
						!(queued_values[0].drain && expected_pushes.size() != 0)) begin
					req = queued_values.pop_front();
					value_bits <= req.bits;
					offering = 1'b1;
					send_gap = draw_wait(send_burst);
				end
			end
			in_valid <= offering;
		end
	end

	// receiver: random stall after each result, plus one long hold-off
	int  recv_wait = 0;
	int  recv_burst = 0;
	int  recv_hold = 0;
	bit  hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				recv_hold = LONG_HOLD;
			end
			if (out_took)
				recv_wait = draw_wait(recv_burst);
			if (recv_hold > 0) begin
				recv_hold--;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on progress of either channel
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("x87_single_float_push_tb failed");
				$finish;
			end
		end
	end

	task automatic queue_value(input logic [31:0] bits, input bit drain);
		push_request_t req;
		req.bits = bits;
		req.drain = drain;
		queued_values.push_back(req);
	endtask

	initial begin
		logic [31:0] v;
		int          kind;
		int          lead;
		shadow_status = '0;
		shadow_tags = x87sfp_pkg::TAGS_EMPTY;
		for (int i = 0; i < x87sfp_pkg::STACK_DEPTH; i++)
			shadow_stack[i] = '0;

		// directed pushes: zeros, subnormal edges, normal extremes, specials
		queue_value(32'h0000_0000, 1'b0); // +0
		queue_value(32'h8000_0000, 1'b0); // -0, sign dropped
		queue_value(32'h0000_0001, 1'b0); // smallest subnormal
		queue_value(32'h8000_0400, 1'b0); // negative subnormal, mid lead bit
		queue_value(32'h007F_FFFF, 1'b0); // largest subnormal
		queue_value(32'h0040_0000, 1'b0); // subnormal, top fraction bit only
		queue_value(32'h0080_0000, 1'b0); // smallest normal
		queue_value(32'h7F7F_FFFF, 1'b0); // largest normal
		queue_value(32'hFF7F_FFFF, 1'b1); // most negative normal, after a drain
		queue_value(32'h3F80_0000, 1'b0); // 1.0
		queue_value(32'hBF80_0000, 1'b0); // -1.0
		queue_value(32'h7F80_0000, 1'b0); // +inf, rejected
		queue_value(32'hFF80_0000, 1'b0); // -inf, rejected
		queue_value(32'h7FC0_0000, 1'b0); // quiet nan
		queue_value(32'h7F80_0001, 1'b0); // signaling nan
		queue_value(32'hFFFF_FFFF, 1'b0); // all ones nan
		queue_value(32'h4049_0FDB, 1'b0); // pi
		queue_value(32'h0000_0000, 1'b0); // zero over a reused slot
		queue_value(32'h5555_5555, 1'b0);
		queue_value(32'hAAAA_AAAA, 1'b0);

		// random pushes, mostly finite values spread over every class
		for (int n = 0; n < RANDOM_PUSHES; n++) begin
			kind = $urandom_range(0, 9);
			v = $urandom;
			case (kind) inside
				[0:3]: begin
					v[30:23] = 8'($urandom_range(1, 254));
				end
				[4:5]: begin
					// subnormal with a random lead bit position
					lead = $urandom_range(0, 22);
					v[30:23] = 8'd0;
					v[22:0] = (v[22:0] & ((23'd1 << lead) - 23'd1)) | (23'd1 << lead);
				end
				6: begin
					v[30:0] = '0;
				end
				7: begin
					v[30:23] = x87sfp_pkg::SGL_EXP_SPECIAL;
					if ($urandom_range(0, 2) == 0)
						v[22:0] = '0;
				end
				default: begin
				end
			endcase
			queue_value(v, n == 300 || n == 450);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all requests offered and taken, then all results back
		while (queued_values.size() != 0 || in_valid || expected_pushes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_pushes.size() != 0) begin
			mismatches++;
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				expected_pushes.size());
		end
		if (mismatches == 0)
			$display("x87_single_float_push_tb passed");
		else
			$display("x87_single_float_push_tb failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/x87sfp_pkg.sv
rtl/x87sfp_ram.sv
rtl/x87_single_float_push.sv
rtl/x87sfp_checker.sv
tb/x87_single_float_push_tb.sv
